### rtl/hufs_pkg.sv
// Shared types, character codes and helpers for the https URI field splitter.
// No dependencies; imported by hufs_parse and https_uri_field_splitter.
package hufs_pkg;

    localparam int STATUS_W = 3;
    localparam int OFS_W    = 11;
    localparam int PORT_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int ACC_W    = 20;

    localparam logic [PORT_W-1:0] DEFAULT_PORT = 16'd443;
    localparam logic [ACC_W-1:0]  PORT_LIMIT   = 20'd65535;

    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_QUEST  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_PREFIX = 3'd1,
        ST_HOST   = 3'd2,
        ST_PORT   = 3'd3,
        ST_LONG   = 3'd4
    } t_status;

    typedef enum logic [7:0] {
        PH_PREFIX    = 8'b0000_0001,
        PH_HOSTSTART = 8'b0000_0010,
        PH_HOST      = 8'b0000_0100,
        PH_V6        = 8'b0000_1000,
        PH_AFTERV6   = 8'b0001_0000,
        PH_PORT      = 8'b0010_0000,
        PH_PATH      = 8'b0100_0000,
        PH_FRAG      = 8'b1000_0000
    } t_phase;

    // first member sits in the top bits, so status ends up in bits 2:0
    typedef struct packed {
        logic                path_default;
        logic [OFS_W-1:0]    path_length;
        logic [OFS_W-1:0]    path_offset;
        logic [PORT_W-1:0]   port_number;
        logic [OFS_W-1:0]    hostport_length;
        logic [OFS_W-1:0]    host_length;
        logic [OFS_W-1:0]    host_offset;
        t_status             status;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    function automatic logic [CHAR_W-1:0] scheme_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h68;
            3'd1:    ch = 8'h74;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h70;
            3'd4:    ch = 8'h73;
            3'd5:    ch = CH_COLON;
            default: ch = CH_SLASH;
        endcase
        return ch;
    endfunction

    function automatic logic is_path_mark(input logic [CHAR_W-1:0] ch);
        return ch inside {CH_SLASH, CH_QUEST, CH_HASH};
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
        return ch inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage

### rtl/https_uri_field_splitter.sv
// Top level of the https URI field splitter: input word register, parser, result register.
// Depends on hufs_pkg and hufs_parse.
//
// Usage:
//   s_axis carries the URI one character per word; tlast marks its final character.
//   m_axis carries one result word per URI, sent after the word with tlast set.
//   The final character first sits in the input register; then its parse result
//   loads the result register.
//   Throughput: one character per cycle, back to back, including across URIs,
//   except while a final character waits for the result register (see below);
//   the per-character update is one phase step plus a multiply by ten for the port.
//   A URI longer than MAX_URI_LEN characters reports status 4; positions saturate.
//   Reset clears the parse state, the input register and the result valid flag;
//   the next character after reset is the first of a new URI.
//   When m_axis_tready is low the result word holds; ordinary characters keep
//   flowing, and only a final character waits in the input register until the
//   result register is free; while it waits, s_axis_tready is low.
module https_uri_field_splitter #(
    parameter int MAX_URI_LEN = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // char_code
    input  logic                          s_axis_tlast,   // end_mark
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status, host_offset, host_length, hostport_length, port_number,
    // path_offset, path_length, path_default, zero pad
    output logic [hufs_pkg::TDATA_W-1:0]  m_axis_tdata
);
    import hufs_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out_data;

    logic              out_free;
    logic              step;
    logic              res_valid;
    t_result           res;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    hufs_parse #(
        .MAX_URI_LEN(MAX_URI_LEN)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_char     (r_in_char),
        .i_last     (r_in_last),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W - RESULT_W){1'b0}}, r_out_data};

endmodule

### rtl/hufs_parse.sv
// Per-character parse state and update logic, with the end-of-URI result.
// Depends on hufs_pkg.
module hufs_parse #(
    parameter int MAX_URI_LEN = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [hufs_pkg::CHAR_W-1:0] i_char,
    input  logic                      i_last,
    output logic                      o_res_valid,
    output hufs_pkg::t_result         o_res
);
    import hufs_pkg::*;

    localparam int POS_W = $clog2(MAX_URI_LEN + 1);
    localparam int EXT_W = (POS_W > OFS_W) ? POS_W : OFS_W;
    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_URI_LEN);
    localparam logic [POS_W-1:0] POS_SEVEN  = POS_W'(7);
    localparam logic [POS_W-1:0] HOST_RESET = POS_W'(8);
    localparam logic [EXT_W-1:0] HP_BASE    = EXT_W'(8);

    t_phase              r_phase,      n_phase;
    t_status             r_err,        n_err;
    logic [POS_W-1:0]    r_position,   n_position;
    logic [POS_W-1:0]    r_host_begin, n_host_begin;
    logic [POS_W-1:0]    r_host_count, n_host_count;
    logic [PORT_W-1:0]   r_port_acc,   n_port_acc;
    logic                r_port_seen,  n_port_seen;
    logic [POS_W-1:0]    r_path_begin, n_path_begin;
    logic [POS_W-1:0]    r_path_count, n_path_count;

    logic [ACC_W-1:0]    port_next;
    t_status             fin_err;
    logic [POS_W-1:0]    fin_path_begin;
    logic [EXT_W-1:0]    x_host_begin, x_host_count, x_hostport;
    logic [EXT_W-1:0]    x_path_begin, x_path_count;

    assign port_next = (ACC_W'(r_port_acc) << 3) + (ACC_W'(r_port_acc) << 1)
                     + ACC_W'(i_char[3:0]);

    always_comb begin
        n_phase      = r_phase;
        n_err        = r_err;
        n_position   = r_position;
        n_host_begin = r_host_begin;
        n_host_count = r_host_count;
        n_port_acc   = r_port_acc;
        n_port_seen  = r_port_seen;
        n_path_begin = r_path_begin;
        n_path_count = r_path_count;

        if (r_position >= POS_MAX) begin
            n_err = ST_LONG;
        end else begin
            n_position = r_position + 1'b1;
            if (r_err == ST_OK) begin
                case (r_phase)
                    PH_PREFIX: begin
                        if (r_position > POS_SEVEN ||
                            i_char != scheme_char(r_position[2:0])) begin
                            n_err = ST_PREFIX;
                        end else if (r_position == POS_SEVEN) begin
                            n_phase = PH_HOSTSTART;
                        end
                    end
                    PH_HOSTSTART: begin
                        if (i_char == CH_LBRACK) begin
                            n_host_begin = r_position + 1'b1;
                            n_host_count = '0;
                            n_phase      = PH_V6;
                        end else if (i_char == CH_COLON || is_path_mark(i_char)) begin
                            n_err = ST_HOST;
                        end else begin
                            n_host_begin = r_position;
                            n_host_count = POS_W'(1);
                            n_phase      = PH_HOST;
                        end
                    end
                    PH_HOST: begin
                        if (i_char == CH_COLON) begin
                            n_port_seen = 1'b1;
                            n_port_acc  = '0;
                            n_phase     = PH_PORT;
                        end else if (is_path_mark(i_char)) begin
                            n_path_begin = r_position;
                            n_path_count = (i_char == CH_HASH) ? '0 : POS_W'(1);
                            n_phase      = (i_char == CH_HASH) ? PH_FRAG : PH_PATH;
                        end else begin
                            n_host_count = r_host_count + 1'b1;
                        end
                    end
                    PH_V6: begin
                        if (i_char == CH_RBRACK) begin
                            if (r_host_count == '0) begin
                                n_err = ST_HOST;
                            end else begin
                                n_phase = PH_AFTERV6;
                            end
                        end else begin
                            n_host_count = r_host_count + 1'b1;
                        end
                    end
                    PH_AFTERV6: begin
                        if (i_char == CH_COLON) begin
                            n_port_seen = 1'b1;
                            n_port_acc  = '0;
                            n_phase     = PH_PORT;
                        end else begin
                            n_path_begin = r_position;
                            n_path_count = (i_char == CH_HASH) ? '0 : POS_W'(1);
                            n_phase      = (i_char == CH_HASH) ? PH_FRAG : PH_PATH;
                        end
                    end
                    PH_PORT: begin
                        if (is_path_mark(i_char)) begin
                            if (r_port_acc == '0) begin
                                n_err = ST_PORT;
                            end else begin
                                n_path_begin = r_position;
                                n_path_count = (i_char == CH_HASH) ? '0 : POS_W'(1);
                                n_phase      = (i_char == CH_HASH) ? PH_FRAG : PH_PATH;
                            end
                        end else if (is_digit(i_char)) begin
                            if (port_next > PORT_LIMIT) begin
                                n_err = ST_PORT;
                            end else begin
                                n_port_acc = port_next[PORT_W-1:0];
                            end
                        end else begin
                            n_err = ST_PORT;
                        end
                    end
                    PH_PATH: begin
                        if (i_char == CH_HASH) begin
                            n_phase = PH_FRAG;
                        end else begin
                            n_path_count = r_path_count + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // end-of-URI checks on the updated state
    always_comb begin
        fin_err        = n_err;
        fin_path_begin = n_path_begin;
        if (n_err == ST_OK) begin
            case (n_phase)
                PH_PREFIX, PH_HOSTSTART: fin_err = ST_PREFIX;
                PH_V6:                   fin_err = ST_HOST;
                PH_PORT: begin
                    if (n_port_acc == '0) begin
                        fin_err = ST_PORT;
                    end else begin
                        fin_path_begin = n_position;
                    end
                end
                PH_HOST, PH_AFTERV6:     fin_path_begin = n_position;
                default: begin
                end
            endcase
        end
    end

    assign x_host_begin = EXT_W'(n_host_begin);
    assign x_host_count = EXT_W'(n_host_count);
    assign x_path_begin = EXT_W'(fin_path_begin);
    assign x_path_count = EXT_W'(n_path_count);
    assign x_hostport   = x_path_begin - HP_BASE;

    always_comb begin
        o_res        = '0;
        o_res.status = fin_err;
        if (fin_err == ST_OK) begin
            o_res.host_offset     = x_host_begin[OFS_W-1:0];
            o_res.host_length     = x_host_count[OFS_W-1:0];
            o_res.hostport_length = x_hostport[OFS_W-1:0];
            o_res.port_number     = n_port_seen ? n_port_acc : DEFAULT_PORT;
            o_res.path_offset     = x_path_begin[OFS_W-1:0];
            o_res.path_length     = x_path_count[OFS_W-1:0];
            o_res.path_default    = (n_path_count == '0);
        end
    end

    assign o_res_valid = i_step & i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase      <= PH_PREFIX;
            r_err        <= ST_OK;
            r_position   <= '0;
            r_host_begin <= HOST_RESET;
            r_host_count <= '0;
            r_port_acc   <= '0;
            r_port_seen  <= 1'b0;
            r_path_begin <= '0;
            r_path_count <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_err        <= n_err;
            r_position   <= n_position;
            r_host_begin <= n_host_begin;
            r_host_count <= n_host_count;
            r_port_acc   <= n_port_acc;
            r_port_seen  <= n_port_seen;
            r_path_begin <= n_path_begin;
            r_path_count <= n_path_count;
        end
    end

endmodule
